FILE: src/assert_macros.svh
// Assertion macros for the RTL of the blob frame parser.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: src/cbfp_pkg.sv
// Package of the blob frame parser: sizes, sync bytes, codes, payload types and a little-endian word helper.
// Depends on nothing; used by the channel interfaces and the top level.
package cbfp_pkg;

   localparam int MAX_BLOBS    = 8;
   localparam int WINDOW_BYTES = 16;
   localparam int BLOCK_BYTES  = 14;
   localparam int FRAME_BYTES  = 16;

   localparam int WIN_LEN_W = $clog2(WINDOW_BYTES + 1);
   localparam int CNT_W     = $clog2(MAX_BLOBS + 1);
   localparam int IDX_W     = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int BLOB_W    = 64;

   localparam logic [7:0] SYNC_LO = 8'h55;
   localparam logic [7:0] SYNC_HI = 8'hAA;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] CLS_WAIT  = 2'd0;
   localparam logic [1:0] CLS_BAD   = 2'd1;
   localparam logic [1:0] CLS_FRAME = 2'd2;
   localparam logic [1:0] CLS_BLOCK = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } cbfp_req_type;

   typedef struct packed {
      logic        frame_swapped;
      logic        read_valid;
      logic [15:0] blob_x;
      logic [15:0] blob_y;
      logic [15:0] blob_width;
      logic [15:0] blob_height;
      logic [7:0]  read_side_count;
   } cbfp_rsp_type;

   function automatic logic [15:0] le_word(input logic [7:0] lo, input logic [7:0] hi);
      return {hi, lo};
   endfunction

endpackage

FILE: src/cbfp_req_if.sv
// Request channel of the blob frame parser: valid, ready and the request payload.
// Depends on cbfp_pkg.
interface cbfp_req_if;
   logic                    valid;
   logic                    ready;
   cbfp_pkg::cbfp_req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/cbfp_rsp_if.sv
// Response channel of the blob frame parser: valid, ready and the response payload.
// Depends on cbfp_pkg.
interface cbfp_rsp_if;
   logic                    valid;
   logic                    ready;
   cbfp_pkg::cbfp_rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/camera_blob_frame_parser.sv
// Camera blob frame parser: window, classifier, double-buffered blob memory.
// Depends on cbfp_pkg, cbfp_req_if, cbfp_rsp_if and assert_macros.svh.
//
// One request is taken per clock while the response side does not stall, and
// each gives exactly one response. A byte request updates the 16-byte sync
// window, checks the five-word checksum and appends the blob to the write bank
// of the blob memory in the cycle it is accepted; a read request addresses the
// read bank in that cycle, and its data passes the registered read of the blob
// memory and then the output register. Each request is a read or a byte, so a
// read and an append never fall in the same cycle and no interlock is needed.
`include "assert_macros.svh"

module camera_blob_frame_parser (
   input  logic       clock,
   input  logic       reset,
   cbfp_req_if.sink   req_chan,
   cbfp_rsp_if.source rsp_chan
);

   localparam int W = cbfp_pkg::WINDOW_BYTES;

   logic [7:0]                  win_ff [W];
   logic [7:0]                  win_in [W];
   logic [7:0]                  nw     [W];
   logic [cbfp_pkg::WIN_LEN_W-1:0] len_ff, len_in, len_eff, nl;
   logic [cbfp_pkg::CNT_W-1:0]  cnt_ff [2];
   logic [cbfp_pkg::CNT_W-1:0]  cnt_in [2];
   logic                        wb_ff, wb_in;

   logic [cbfp_pkg::BLOB_W-1:0] blob_mem [cbfp_pkg::MEM_DEPTH];
   logic [cbfp_pkg::BLOB_W-1:0] rd_data_ff;
   logic [cbfp_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic [cbfp_pkg::BLOB_W-1:0] wr_data;
   logic                        rd_en, wr_en;

   logic                        acc, acc_byte, acc_read;
   logic [1:0]                  cls;
   logic [15:0]                 sum4, sum6;
   logic                        do_swap, do_app, app_frame;
   logic                        tgt_bank;
   logic [cbfp_pkg::CNT_W-1:0]  tgt_cnt;
   logic                        rvalid;
   logic [cbfp_pkg::CNT_W-1:0]  rcount;

   logic                        s1_valid_ff, s1_swap_ff, s1_rvalid_ff, s1_go;
   logic [cbfp_pkg::CNT_W-1:0]  s1_count_ff;
   logic                        out_valid_ff;
   cbfp_pkg::cbfp_rsp_type      out_ff;
   logic [cbfp_pkg::BLOB_W-1:0] blob_sel;

   assign s1_go          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign acc            = req_chan.valid && req_chan.ready;
   assign acc_byte       = acc && (req_chan.payload.req_type == cbfp_pkg::REQ_BYTE);
   assign acc_read       = acc && (req_chan.payload.req_type == cbfp_pkg::REQ_READ);

   // insert the new byte; an overfull window starts over
   always_comb begin
      len_eff = (len_ff >= cbfp_pkg::WIN_LEN_W'(W)) ? '0 : len_ff;
      for (int i = 0; i < W; i++) begin
         if (cbfp_pkg::WIN_LEN_W'(i) == len_eff) begin
            nw[i] = req_chan.payload.rx_byte;
         end else if (len_ff >= cbfp_pkg::WIN_LEN_W'(W)) begin
            nw[i] = 8'h00;
         end else begin
            nw[i] = win_ff[i];
         end
      end
      nl = len_eff + 1'b1;
   end

   always_comb begin
      sum4 = cbfp_pkg::le_word(nw[4], nw[5]) + cbfp_pkg::le_word(nw[6], nw[7])
           + cbfp_pkg::le_word(nw[8], nw[9]) + cbfp_pkg::le_word(nw[10], nw[11])
           + cbfp_pkg::le_word(nw[12], nw[13]);
      sum6 = cbfp_pkg::le_word(nw[6], nw[7]) + cbfp_pkg::le_word(nw[8], nw[9])
           + cbfp_pkg::le_word(nw[10], nw[11]) + cbfp_pkg::le_word(nw[12], nw[13])
           + cbfp_pkg::le_word(nw[14], nw[15]);
   end

   always_comb begin
      priority if (nw[0] != cbfp_pkg::SYNC_LO) begin
         cls = cbfp_pkg::CLS_BAD;
      end else if (nl >= cbfp_pkg::WIN_LEN_W'(2) && nw[1] != cbfp_pkg::SYNC_HI) begin
         cls = cbfp_pkg::CLS_BAD;
      end else if (nl < cbfp_pkg::WIN_LEN_W'(cbfp_pkg::BLOCK_BYTES)) begin
         cls = cbfp_pkg::CLS_WAIT;
      end else if (nw[2] == cbfp_pkg::SYNC_LO && nw[3] == cbfp_pkg::SYNC_HI) begin
         if (nl < cbfp_pkg::WIN_LEN_W'(cbfp_pkg::FRAME_BYTES)) begin
            cls = cbfp_pkg::CLS_WAIT;
         end else begin
            cls = (cbfp_pkg::le_word(nw[4], nw[5]) == sum6) ?
                  cbfp_pkg::CLS_FRAME : cbfp_pkg::CLS_BAD;
         end
      end else begin
         cls = (cbfp_pkg::le_word(nw[2], nw[3]) == sum4) ?
               cbfp_pkg::CLS_BLOCK : cbfp_pkg::CLS_BAD;
      end
   end

   // swap, append and window update
   always_comb begin
      do_swap   = acc_byte && (cls == cbfp_pkg::CLS_FRAME || cls == cbfp_pkg::CLS_BAD)
                  && (cnt_ff[wb_ff] != '0);
      tgt_bank  = do_swap ? ~wb_ff : wb_ff;
      tgt_cnt   = do_swap ? '0 : cnt_ff[wb_ff];
      app_frame = (cls == cbfp_pkg::CLS_FRAME);
      do_app    = acc_byte && (app_frame || cls == cbfp_pkg::CLS_BLOCK)
                  && (tgt_cnt < cbfp_pkg::CNT_W'(cbfp_pkg::MAX_BLOBS));
      wr_en     = do_app;
      wr_addr   = {tgt_bank, tgt_cnt[cbfp_pkg::IDX_W-1:0]};
      if (app_frame) begin
         wr_data = {cbfp_pkg::le_word(nw[14], nw[15]), cbfp_pkg::le_word(nw[12], nw[13]),
                    cbfp_pkg::le_word(nw[10], nw[11]), cbfp_pkg::le_word(nw[8], nw[9])};
      end else begin
         wr_data = {cbfp_pkg::le_word(nw[12], nw[13]), cbfp_pkg::le_word(nw[10], nw[11]),
                    cbfp_pkg::le_word(nw[8], nw[9]), cbfp_pkg::le_word(nw[6], nw[7])};
      end

      wb_in     = do_swap ? ~wb_ff : wb_ff;
      cnt_in[0] = cnt_ff[0];
      cnt_in[1] = cnt_ff[1];
      if (do_swap) begin
         cnt_in[tgt_bank] = '0;
      end
      if (do_app) begin
         cnt_in[tgt_bank] = tgt_cnt + 1'b1;
      end

      win_in = win_ff;
      len_in = len_ff;
      if (acc_byte) begin
         unique case (cls)
            cbfp_pkg::CLS_WAIT: begin
               win_in = nw;
               len_in = nl;
            end
            cbfp_pkg::CLS_BAD: begin
               for (int i = 0; i < W - 1; i++) begin
                  win_in[i] = nw[i + 1];
               end
               win_in[W-1] = 8'h00;
               len_in = nl - 1'b1;
            end
            default: begin
               for (int i = 0; i < W; i++) begin
                  win_in[i] = 8'h00;
               end
               len_in = '0;
            end
         endcase
      end
   end

   // read side lookup
   always_comb begin
      rvalid  = acc_read
                && (req_chan.payload.read_index < 8'(cbfp_pkg::MAX_BLOBS))
                && (req_chan.payload.read_index < 8'(cnt_ff[~wb_ff]));
      rd_en   = acc_read;
      rd_addr = {~wb_ff, req_chan.payload.read_index[cbfp_pkg::IDX_W-1:0]};
      rcount  = cnt_ff[~wb_in];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blob_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= blob_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < W; i++) begin
            win_ff[i] <= 8'h00;
         end
         len_ff    <= '0;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         wb_ff     <= 1'b0;
      end else begin
         win_ff    <= win_in;
         len_ff    <= len_in;
         cnt_ff[0] <= cnt_in[0];
         cnt_ff[1] <= cnt_in[1];
         wb_ff     <= wb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_swap_ff   <= do_swap;
         s1_rvalid_ff <= rvalid;
         s1_count_ff  <= (cbfp_pkg::CNT_W)'(rcount);
      end
   end

   assign blob_sel = s1_rvalid_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_ff.frame_swapped   <= s1_swap_ff;
         out_ff.read_valid      <= s1_rvalid_ff;
         out_ff.blob_x          <= blob_sel[15:0];
         out_ff.blob_y          <= blob_sel[31:16];
         out_ff.blob_width      <= blob_sel[47:32];
         out_ff.blob_height     <= blob_sel[63:48];
         out_ff.read_side_count <= 8'(s1_count_ff);
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   `CHK_NEXT(a_swap_flips_bank, clock, reset, do_swap, wb_ff != $past(wb_ff))
   `CHK_NEXT(a_held_read_data, clock, reset, s1_valid_ff && s1_rvalid_ff && !s1_go,
             $stable(rd_data_ff))
   `CHK_NEXT(a_window_not_full, clock, reset, acc_byte,
             len_ff < cbfp_pkg::WIN_LEN_W'(cbfp_pkg::WINDOW_BYTES))
   `CHK_SAME(a_count_bound, clock, reset, acc_read,
             cnt_ff[~wb_ff] <= cbfp_pkg::CNT_W'(cbfp_pkg::MAX_BLOBS))

endmodule
